// File: rtl/itoa_pkg.sv
// ============================================================================
// itoa_pkg: shared types and constants of the integer to ASCII converter
// Holds the payload structs, the controller states, the digit datapath
// control group and the character encoding helper.
// ============================================================================
package itoa_pkg;

    // Width of the converted integer; the value port keeps its full 64 bits.
    localparam int VALUE_BITS  = 64;
    localparam int IN_BITS     = 64;
    localparam int DIGITS      = 20;
    localparam int DIGIT_BITS  = DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W   = $clog2(DIGITS + 1);
    localparam int CHAR_BITS   = 7;
    localparam int COUNT_BITS  = 5;

    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 7'h2D;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    typedef struct packed {
        logic signed [IN_BITS-1:0] value;
        logic                      cmd;
    } num_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0]  char_code;
        logic                  last;
        logic [COUNT_BITS-1:0] char_count;
    } chr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic step;
        logic shift;
    } digit_ctrl_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_BITS-1:0] code;
        if (d >= 4'd10)
        begin
            code = CH_A + CHAR_BITS'(d - 4'd10);
        end
        else
        begin
            code = CH_ZERO + CHAR_BITS'(d);
        end
        return code;
    endfunction

endpackage

// File: rtl/integer_to_ascii_converter_top.sv
// ============================================================================
// integer_to_ascii_converter_top: integer to ASCII text converter
// Decimal: accept, a bit-serial shift/add-3 pass over every value bit, a scan
// past leading zero digits, a minus sign if negative, then one character per
// cycle while the output can take one. Hex skips the conversion. The scan drops
// one nibble per cycle; output stalls hold the sign and the characters. Reset
// empties the controller and output register.
// ============================================================================
module integer_to_ascii_converter_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            num_valid,
    output logic            num_ready,
    input  itoa_pkg::num_t  num_data,
    output logic            chr_valid,
    input  logic            chr_ready,
    output itoa_pkg::chr_t  chr_data
);

    // Controller registers.
    itoa_pkg::state_t                   state_reg;
    itoa_pkg::state_t                   state_next;
    logic [itoa_pkg::BIT_CNT_W-1:0]     bit_cnt_reg;
    logic [itoa_pkg::BIT_CNT_W-1:0]     bit_cnt_next;
    logic [itoa_pkg::DIG_CNT_W-1:0]     dig_cnt_reg;
    logic [itoa_pkg::DIG_CNT_W-1:0]     dig_cnt_next;
    logic [itoa_pkg::COUNT_BITS-1:0]    cnt_reg;
    logic [itoa_pkg::COUNT_BITS-1:0]    cnt_next;
    logic                               neg_reg;
    logic                               neg_next;

    // Input side: the low VALUE_BITS bits, read as two's complement.
    logic [itoa_pkg::VALUE_BITS-1:0]    raw;
    logic                               in_neg;
    logic [itoa_pkg::VALUE_BITS-1:0]    mag;
    logic                               accept;

    itoa_pkg::digit_ctrl_t              dctrl;
    logic [3:0]                         top_digit;
    logic                               push;
    itoa_pkg::chr_t                     push_data;
    logic                               can_push;
    logic                               last_digit;

    assign raw    = num_data.value[itoa_pkg::VALUE_BITS-1:0];
    // Hex mode prints the raw pattern, so only decimal mode looks at the sign.
    assign in_neg = (num_data.cmd == itoa_pkg::CMD_DEC) && raw[itoa_pkg::VALUE_BITS-1];
    // Negating in VALUE_BITS unsigned bits gives the most negative value its
    // full magnitude.
    assign mag    = in_neg ? (~raw + itoa_pkg::VALUE_BITS'(1)) : raw;

    assign num_ready  = (state_reg == itoa_pkg::ST_IDLE);
    assign accept     = num_valid && num_ready;
    assign last_digit = (dig_cnt_reg == itoa_pkg::DIG_CNT_W'(1));

    itoa_digits u_digits (
        .clk       (clk),
        .ctrl      (dctrl),
        .mag       (mag),
        .top_digit (top_digit)
    );

    itoa_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .chr_valid (chr_valid),
        .chr_ready (chr_ready),
        .chr_data  (chr_data)
    );

    // Next-state logic. The scan drops leading zero digits one per cycle but
    // always keeps the last digit, so zero prints as a single '0'.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (num_data.cmd == itoa_pkg::CMD_HEX)
                    begin
                        state_next = itoa_pkg::ST_SKIP;
                    end
                    else
                    begin
                        state_next = itoa_pkg::ST_DABBLE;
                    end
                end
            end
            itoa_pkg::ST_DABBLE:
            begin
                if (bit_cnt_reg == itoa_pkg::BIT_CNT_W'(itoa_pkg::VALUE_BITS - 1))
                begin
                    state_next = itoa_pkg::ST_SKIP;
                end
            end
            itoa_pkg::ST_SKIP:
            begin
                if (top_digit != 4'd0 || last_digit)
                begin
                    state_next = neg_reg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_SIGN:
            begin
                if (can_push)
                begin
                    state_next = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT:
            begin
                if (can_push && last_digit)
                begin
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath control. The running count includes the sign, and
    // the total goes out only with the final character.
    always_comb
    begin
        dctrl        = '0;
        push         = 1'b0;
        push_data    = '0;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        case (state_reg)
            itoa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dctrl.load_dec = (num_data.cmd == itoa_pkg::CMD_DEC);
                    dctrl.load_hex = (num_data.cmd == itoa_pkg::CMD_HEX);
                    bit_cnt_next   = '0;
                    dig_cnt_next   = itoa_pkg::DIG_CNT_W'(itoa_pkg::DIGITS);
                    cnt_next       = '0;
                    neg_next       = in_neg;
                end
            end
            itoa_pkg::ST_DABBLE:
            begin
                dctrl.step   = 1'b1;
                bit_cnt_next = bit_cnt_reg + itoa_pkg::BIT_CNT_W'(1);
            end
            itoa_pkg::ST_SKIP:
            begin
                if (top_digit == 4'd0 && !last_digit)
                begin
                    dctrl.shift  = 1'b1;
                    dig_cnt_next = dig_cnt_reg - itoa_pkg::DIG_CNT_W'(1);
                end
            end
            itoa_pkg::ST_SIGN:
            begin
                push_data.char_code = itoa_pkg::CH_MINUS;
                if (can_push)
                begin
                    push     = 1'b1;
                    cnt_next = cnt_reg + itoa_pkg::COUNT_BITS'(1);
                end
            end
            itoa_pkg::ST_EMIT:
            begin
                push_data.char_code  = itoa_pkg::digit_char(top_digit);
                push_data.last       = last_digit;
                push_data.char_count = last_digit ?
                                       (cnt_reg + itoa_pkg::COUNT_BITS'(1)) : '0;
                if (can_push)
                begin
                    push         = 1'b1;
                    dctrl.shift  = 1'b1;
                    dig_cnt_next = dig_cnt_reg - itoa_pkg::DIG_CNT_W'(1);
                    cnt_next     = cnt_reg + itoa_pkg::COUNT_BITS'(1);
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= itoa_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            cnt_reg     <= cnt_next;
            neg_reg     <= neg_next;
        end
    end

    // An accepted value keeps the input closed for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready |=> !num_ready)
        else $error("input accepted twice in a row");

    // Only the final character carries a count, and it is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && chr_data.last |-> chr_data.char_count != '0)
        else $error("final character without a count");

    assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && !chr_data.last |-> chr_data.char_count == '0)
        else $error("count on a character that is not final");

    // While characters are being sent, at least one digit remains to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == itoa_pkg::ST_EMIT |-> dig_cnt_reg != '0)
        else $error("digit counter ran out during emission");

endmodule

// File: rtl/itoa_digits.sv
// ============================================================================
// itoa_digits: bit-serial binary to BCD converter and digit shift register
// Decimal values enter through a binary shift register one bit per cycle
// and are folded into twenty BCD digits by shift and add-3. Hexadecimal
// values load their nibbles directly. Digits leave from the top, one
// nibble per shift.
// ============================================================================
module itoa_digits (
    input  logic                             clk,
    input  itoa_pkg::digit_ctrl_t            ctrl,
    input  logic [itoa_pkg::VALUE_BITS-1:0]  mag,
    output logic [3:0]                       top_digit
);

    logic [itoa_pkg::VALUE_BITS-1:0] bin_reg;
    logic [itoa_pkg::VALUE_BITS-1:0] bin_next;
    logic [itoa_pkg::DIGIT_BITS-1:0] bcd_reg;
    logic [itoa_pkg::DIGIT_BITS-1:0] bcd_next;
    logic [itoa_pkg::DIGIT_BITS-1:0] bcd_adj;

    // Each BCD digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < itoa_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.load_dec)
        begin
            bin_next = mag;
            bcd_next = '0;
        end
        else if (ctrl.load_hex)
        begin
            bcd_next = itoa_pkg::DIGIT_BITS'(mag);
        end
        else if (ctrl.step)
        begin
            bin_next = {bin_reg[itoa_pkg::VALUE_BITS-2:0], 1'b0};
            bcd_next = {bcd_adj[itoa_pkg::DIGIT_BITS-2:0],
                        bin_reg[itoa_pkg::VALUE_BITS-1]};
        end
        else if (ctrl.shift)
        begin
            bcd_next = {bcd_reg[itoa_pkg::DIGIT_BITS-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[itoa_pkg::DIGIT_BITS-1 -: 4];

endmodule

// File: rtl/itoa_obuf.sv
// ============================================================================
// itoa_obuf: output register of the character channel
// Holds one character until the downstream side takes it and accepts a
// new one in the same cycle that the held one leaves.
// ============================================================================
module itoa_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  itoa_pkg::chr_t  push_data,
    output logic            can_push,
    output logic            chr_valid,
    input  logic            chr_ready,
    output itoa_pkg::chr_t  chr_data
);

    logic           valid_reg;
    logic           valid_next;
    itoa_pkg::chr_t data_reg;

    assign can_push = !valid_reg || chr_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (chr_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign chr_valid = valid_reg;
    assign chr_data  = data_reg;

endmodule
